### hw/rtl/cv3_pkg.sv
// ---------------------------------------------------------------------------
// cv3_pkg: shared types and constants of the 3x3 RGB convolver
// Transaction payloads, configuration set, queue entry and arithmetic widths.
// ---------------------------------------------------------------------------
package cv3_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 60;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_TOP_ROW    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_MIDDLE_ROW = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_BOTTOM_ROW = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_BIAS       = 3'd5;

   localparam int COEF_W = 20;
   localparam int PROD_W = 29;
   localparam int ROW_W  = 31;
   localparam int SUM_W  = 34;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic       action;
      logic [7:0] pix_red;
      logic [7:0] pix_green;
      logic [7:0] pix_blue;
      logic [7:0] pix_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic [12:0]        image_width;
      logic [12:0]        image_height;
      logic [59:0]        kernel_top_row;
      logic [59:0]        kernel_middle_row;
      logic [59:0]        kernel_bottom_row;
      logic signed [16:0] output_bias;
   } cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } tap_type;

   // taps[row][col], row 0 top, col 0 left; taps outside the image are zero
   typedef struct packed {
      tap_type [2:0][2:0] taps;
      logic [7:0]         alpha;
      logic               last;
   } entry_type;

endpackage

### hw/rtl/convolve_3x3_rgb.sv
// ---------------------------------------------------------------------------
// convolve_3x3_rgb: streaming zero-padded 3x3 convolution of RGBA pixels
// rsp_valid rises once the transaction that completes its window has passed
//   the intake register, window update and queue write, products, row sums
//   and clamp register. Throughput: one transaction per cycle while
//   req_stall is low; the queue and output register let intake run while
//   a result waits. Synchronous active-high reset clears all counters, the
//   window and the queue; line buffers need no clearing.
// ---------------------------------------------------------------------------
module convolve_3x3_rgb import cv3_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type                cfg_ff;
   logic                   accept;
   logic                   busy;
   logic                   push;
   entry_type              push_data;
   entry_type              head_data;
   logic                   not_empty;
   logic                   pop;
   logic [QUEUE_CNT_W-1:0] q_count;

   // hold intake while the queue could not absorb the transaction in flight
   assign req_stall = (q_count + QUEUE_CNT_W'(busy)) >= QUEUE_CNT_W'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // register file; writes to unused indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width       <= 13'd640;
         cfg_ff.image_height      <= 13'd480;
         cfg_ff.kernel_top_row    <= '0;
         cfg_ff.kernel_middle_row <= 60'd256;
         cfg_ff.kernel_bottom_row <= '0;
         cfg_ff.output_bias       <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:       cfg_ff.image_width       <= csr_data[12:0];
            CSR_IMAGE_HEIGHT:      cfg_ff.image_height      <= csr_data[12:0];
            CSR_KERNEL_TOP_ROW:    cfg_ff.kernel_top_row    <= csr_data;
            CSR_KERNEL_MIDDLE_ROW: cfg_ff.kernel_middle_row <= csr_data;
            CSR_KERNEL_BOTTOM_ROW: cfg_ff.kernel_bottom_row <= csr_data;
            CSR_OUTPUT_BIAS:       cfg_ff.output_bias       <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   // front: raster counting, line buffers, window, tap masking
   cv3_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .accept   (accept),
      .req      (req_payload),
      .busy     (busy),
      .push     (push),
      .push_data(push_data)
   );

   // decouple window production from the arithmetic pipeline
   cv3_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head_data(head_data),
      .not_empty(not_empty),
      .count    (q_count)
   );

   // back: multiply, sum, bias, clamp, output register
   cv3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (not_empty),
      .in_data    (head_data),
      .in_take    (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && q_count == QUEUE_CNT_W'(QUEUE_DEPTH)))
      else $error("window pushed into a full queue");

   a_busy_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction missing from front stage");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from an empty queue");

endmodule

### hw/rtl/cv3_queue.sv
// ---------------------------------------------------------------------------
// cv3_queue: small FIFO between front and back
// Holds classified windows until the arithmetic pipeline takes them.
// ---------------------------------------------------------------------------
module cv3_queue import cv3_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  entry_type              push_data,
   input  logic                   pop,
   output entry_type              head_data,
   output logic                   not_empty,
   output logic [QUEUE_CNT_W-1:0] count
);

   entry_type                 store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    head_ff, head_in;
   logic [QUEUE_PTR_W-1:0]    tail_ff, tail_in;
   logic [QUEUE_CNT_W-1:0]    count_ff, count_in;

   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[tail_ff] <= push_data;
      end
   end

   assign head_data = store_ff[head_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

### hw/rtl/cv3_front.sv
// ---------------------------------------------------------------------------
// cv3_front: pixel intake, line buffers and window
// Counts raster position, reads and rewrites the two line buffers, shifts
// the 3x3 window and pushes masked windows that produce an output.
// ---------------------------------------------------------------------------
module cv3_front import cv3_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      accept,
   input  req_type   req,
   output logic      busy,
   output logic      push,
   output entry_type push_data
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic [13:0] eff_w, eff_h;
   logic [12:0] in_col_ff, in_col_in, in_row_ff, in_row_in;
   logic [12:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [AW-1:0] addr;
   logic emit, col_end, row_end, last;
   logic [2:0] row_ok, col_ok;
   logic [8:0] mask;

   logic [31:0] line0_mem [MAX_WIDTH];
   logic [31:0] line1_mem [MAX_WIDTH];

   logic          s1_v_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [31:0]   s1_pix_ff;
   logic          s1_emit_ff, s1_last_ff, s1_byp_ff;
   logic [8:0]    s1_mask_ff;
   logic [31:0]   byp0_ff, byp1_ff, rd0_ff, rd1_ff;
   logic [31:0]   mid, top;
   logic [31:0]   win_ff [3][3];
   logic [31:0]   col_new [3];

   always_comb begin
      eff_w = {1'b0, cfg.image_width};
      if (cfg.image_width == '0) eff_w = 14'd1;
      else if ({1'b0, cfg.image_width} > 14'(MAX_WIDTH)) eff_w = 14'(MAX_WIDTH);
      eff_h = {1'b0, cfg.image_height};
      if (cfg.image_height == '0) eff_h = 14'd1;
      else if ({1'b0, cfg.image_height} > 14'(MAX_HEIGHT)) eff_h = 14'(MAX_HEIGHT);
   end

   always_comb begin
      if ({1'b0, in_col_ff} >= 14'(MAX_WIDTH)) addr = AW'(MAX_WIDTH - 1);
      else addr = in_col_ff[AW-1:0];
      emit    = (in_row_ff >= 13'd2) || (in_row_ff == 13'd1 && in_col_ff != '0);
      col_end = ({1'b0, out_col_ff} + 14'd1) >= eff_w;
      row_end = ({1'b0, out_row_ff} + 14'd1) >= eff_h;
      last    = emit && col_end && row_end;
      row_ok[0] = (out_row_ff != '0) && (({1'b0, out_row_ff} - 14'd1) < eff_h);
      row_ok[1] = {1'b0, out_row_ff} < eff_h;
      row_ok[2] = ({1'b0, out_row_ff} + 14'd1) < eff_h;
      col_ok[0] = (out_col_ff != '0) && (({1'b0, out_col_ff} - 14'd1) < eff_w);
      col_ok[1] = {1'b0, out_col_ff} < eff_w;
      col_ok[2] = ({1'b0, out_col_ff} + 14'd1) < eff_w;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mask[r*3+c] = row_ok[r] && col_ok[c];
         end
      end
   end

   // advance raster counters; a frame end returns all four to zero
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept) begin
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (emit) begin
               if (col_end) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 13'd1;
               end else begin
                  out_col_in = out_col_ff + 13'd1;
               end
            end
            if (({1'b0, in_col_ff} + 14'd1) >= eff_w) begin
               in_col_in = '0;
               if (in_row_ff != 13'd8191) in_row_in = in_row_ff + 13'd1;
            end else begin
               in_col_in = in_col_ff + 13'd1;
            end
         end
      end
   end

   assign mid = s1_byp_ff ? byp0_ff : rd0_ff;
   assign top = s1_byp_ff ? byp1_ff : rd1_ff;

   always_comb begin
      col_new[0] = top;
      col_new[1] = mid;
      col_new[2] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         s1_v_ff    <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[c][r] <= '0;
            end
         end
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         s1_v_ff    <= accept;
         if (s1_v_ff) begin
            for (int r = 0; r < 3; r++) begin
               win_ff[0][r] <= win_ff[1][r];
               win_ff[1][r] <= win_ff[2][r];
               win_ff[2][r] <= col_new[r];
            end
         end
      end
   end

   // line buffers: read on accept, rewritten in the following cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rd0_ff <= line0_mem[addr];
         rd1_ff <= line1_mem[addr];
      end
      if (s1_v_ff) begin
         line0_mem[s1_addr_ff] <= s1_pix_ff;
         line1_mem[s1_addr_ff] <= mid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= addr;
         s1_pix_ff  <= req.action ? 32'd0
                       : {req.pix_alpha, req.pix_blue, req.pix_green, req.pix_red};
         s1_emit_ff <= emit;
         s1_last_ff <= last;
         s1_mask_ff <= mask;
         s1_byp_ff  <= s1_v_ff && (s1_addr_ff == addr);
         byp0_ff    <= s1_pix_ff;
         byp1_ff    <= mid;
      end
   end

   always_comb begin
      logic [31:0] p;
      push_data = '0;
      p = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (c == 2) p = col_new[r];
            else p = win_ff[c+1][r];
            if (!s1_mask_ff[r*3+c]) p = '0;
            push_data.taps[r][c].red   = p[7:0];
            push_data.taps[r][c].green = p[15:8];
            push_data.taps[r][c].blue  = p[23:16];
         end
      end
      push_data.alpha = win_ff[2][1][31:24];
      push_data.last  = s1_last_ff;
   end

   assign push = s1_v_ff && s1_emit_ff;
   assign busy = s1_v_ff;

endmodule

### hw/rtl/cv3_back.sv
// ---------------------------------------------------------------------------
// cv3_back: multiply, accumulate, bias and clamp
// Three stages: products, row sums, final sum with clamp into the result.
// ---------------------------------------------------------------------------
module cv3_back import cv3_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   input  entry_type in_data,
   output logic      in_take,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_payload
);

   logic v1_ff, v2_ff, v3_ff, adv1, adv2, adv3;
   logic signed [PROD_W-1:0] prod_ff [3][3][3];   // [row][col][channel]
   logic signed [ROW_W-1:0]  rsum_ff [3][3];      // [row][channel]
   logic [7:0] a1_ff, a2_ff;
   logic       l1_ff, l2_ff;
   logic signed [COEF_W-1:0] k [3][3];
   logic signed [SUM_W-1:0]  total [3];
   logic [7:0] level [3];
   rsp_type    rsp_ff;

   assign adv3    = !v3_ff || !rsp_stall;
   assign adv2    = !v2_ff || adv3;
   assign adv1    = !v1_ff || adv2;
   assign in_take = in_valid && adv1;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         k[0][c] = cfg.kernel_top_row[c*COEF_W +: COEF_W];
         k[1][c] = cfg.kernel_middle_row[c*COEF_W +: COEF_W];
         k[2][c] = cfg.kernel_bottom_row[c*COEF_W +: COEF_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= in_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c][0] <= PROD_W'($signed({1'b0, in_data.taps[r][c].red}))
                                   * PROD_W'(k[r][c]);
               prod_ff[r][c][1] <= PROD_W'($signed({1'b0, in_data.taps[r][c].green}))
                                   * PROD_W'(k[r][c]);
               prod_ff[r][c][2] <= PROD_W'($signed({1'b0, in_data.taps[r][c].blue}))
                                   * PROD_W'(k[r][c]);
            end
         end
         a1_ff <= in_data.alpha;
         l1_ff <= in_data.last;
      end
      if (adv2) begin
         for (int r = 0; r < 3; r++) begin
            for (int ch = 0; ch < 3; ch++) begin
               rsum_ff[r][ch] <= ROW_W'(prod_ff[r][0][ch]) + ROW_W'(prod_ff[r][1][ch])
                                 + ROW_W'(prod_ff[r][2][ch]);
            end
         end
         a2_ff <= a1_ff;
         l2_ff <= l1_ff;
      end
      if (adv3) begin
         rsp_ff.out_red   <= level[0];
         rsp_ff.out_green <= level[1];
         rsp_ff.out_blue  <= level[2];
         rsp_ff.out_alpha <= a2_ff;
         rsp_ff.frame_end <= l2_ff;
      end
   end

   // floor to whole levels, clamp to 0..255
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         total[ch] = SUM_W'(rsum_ff[0][ch]) + SUM_W'(rsum_ff[1][ch])
                     + SUM_W'(rsum_ff[2][ch]) + SUM_W'(cfg.output_bias);
         if (total[ch][SUM_W-1]) level[ch] = 8'd0;
         else if (total[ch][SUM_W-2:16] != '0) level[ch] = 8'd255;
         else level[ch] = total[ch][15:8];
      end
   end

   assign rsp_valid   = v3_ff;
   assign rsp_payload = rsp_ff;

endmodule

### tb/convolve_3x3_rgb_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// convolve_3x3_rgb_test: self-checking bench for the 3x3 RGB convolver
// Streams framed pixels with random kernels, biases and geometry, predicts
// every filtered pixel in a scoreboard and compares results field by field.
// ---------------------------------------------------------------------------
module convolve_3x3_rgb_test;
   import cv3_pkg::*;

   localparam int LINE_MAX  = 4096;
   localparam int ROW_LIMIT = 4096;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   // Scoreboard: a software copy of the convolver and its pending outputs.
   class cv3_scoreboard;
      bit [12:0]        width_reg;
      bit [12:0]        height_reg;
      bit [59:0]        kernel_reg [3];
      bit [16:0]        bias_reg;
      bit [31:0]        line_mem [2*LINE_MAX];
      bit [31:0]        win [3][3];   // [column left..right][row top..bottom]
      int unsigned      in_col, in_row, out_col, out_row;
      rsp_type          pending_pixels [$];
      int unsigned      errors, results, accepted, frames;

      function new();
         width_reg = 640;
         height_reg = 480;
         kernel_reg[0] = 0;
         kernel_reg[1] = 256;
         kernel_reg[2] = 0;
         bias_reg = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_IMAGE_WIDTH:       width_reg = data[12:0];
            CSR_IMAGE_HEIGHT:      height_reg = data[12:0];
            CSR_KERNEL_TOP_ROW:    kernel_reg[0] = data;
            CSR_KERNEL_MIDDLE_ROW: kernel_reg[1] = data;
            CSR_KERNEL_BOTTOM_ROW: kernel_reg[2] = data;
            CSR_OUTPUT_BIAS:       bias_reg = data[16:0];
            default: ;
         endcase
      endfunction

      function bit [7:0] to_level(longint sum);
         if (sum < 0) return 8'd0;
         sum = sum >>> 8;
         return (sum > 255) ? 8'd255 : sum[7:0];
      endfunction

      // Advance the model by one accepted transaction; queue any output pixel.
      function void note_pixel(req_type r);
         int unsigned      w, h, c;
         bit [31:0]        pix, p;
         longint           sum [3];
         logic signed [19:0] coef;
         logic signed [16:0] bias;
         int               x, y;
         bit               last;
         rsp_type          e;
         w = (width_reg == 0) ? 1 : (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
         h = (height_reg == 0) ? 1 : (height_reg > ROW_LIMIT) ? ROW_LIMIT : height_reg;
         accepted++;
         pix = r.action ? 32'd0 : {r.pix_alpha, r.pix_blue, r.pix_green, r.pix_red};
         c = (in_col >= LINE_MAX) ? LINE_MAX - 1 : in_col;
         for (int i = 0; i < 2; i++)
            for (int j = 0; j < 3; j++)
               win[i][j] = win[i+1][j];
         win[2][0] = line_mem[LINE_MAX + c];
         win[2][1] = line_mem[c];
         win[2][2] = pix;
         line_mem[LINE_MAX + c] = line_mem[c];
         line_mem[c] = pix;

         if (in_row >= 2 || (in_row == 1 && in_col >= 1)) begin
            bias = bias_reg;
            for (int ch = 0; ch < 3; ch++) sum[ch] = bias;
            for (int dy = 0; dy < 3; dy++) begin
               y = int'(out_row) + dy - 1;
               if (y < 0 || y >= int'(h)) continue;
               for (int dx = 0; dx < 3; dx++) begin
                  x = int'(out_col) + dx - 1;
                  if (x < 0 || x >= int'(w)) continue;
                  coef = kernel_reg[dy][20*dx +: 20];
                  p = win[dx][dy];
                  for (int ch = 0; ch < 3; ch++)
                     sum[ch] += longint'(p[8*ch +: 8]) * longint'(coef);
               end
            end
            last = (out_col + 1 >= w) && (out_row + 1 >= h);
            e.out_red   = to_level(sum[0]);
            e.out_green = to_level(sum[1]);
            e.out_blue  = to_level(sum[2]);
            e.out_alpha = win[1][1][31:24];
            e.frame_end = last;
            pending_pixels.push_back(e);
            if (last) begin
               in_col = 0; in_row = 0; out_col = 0; out_row = 0;
               return;
            end
            if (out_col + 1 >= w) begin
               out_col = 0;
               out_row++;
            end else begin
               out_col++;
            end
         end
         if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_row < 8191) in_row++;
         end else begin
            in_col++;
         end
      endfunction

      function void report(string field, int exp_v, int act_v);
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
      endfunction

      function void check_result(rsp_type r);
         rsp_type e;
         results++;
         if (pending_pixels.size() == 0) begin
            errors++;
            if (errors <= 40)
               $display("%0t: unexpected output pixel, expected none actual %h", $time, r);
            return;
         end
         e = pending_pixels.pop_front();
         if (e.frame_end) frames++;
         if (r.out_red   !== e.out_red)   report("out_red",   e.out_red,   r.out_red);
         if (r.out_green !== e.out_green) report("out_green", e.out_green, r.out_green);
         if (r.out_blue  !== e.out_blue)  report("out_blue",  e.out_blue,  r.out_blue);
         if (r.out_alpha !== e.out_alpha) report("out_alpha", e.out_alpha, r.out_alpha);
         if (r.frame_end !== e.frame_end) report("frame_end", e.frame_end, r.frame_end);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   cv3_scoreboard sb = new();
   bit            idle_bursts = 1'b1;
   int            stall_left = 0;
   int unsigned   random_items = 0;
   int unsigned   settings = 0;

   convolve_3x3_rgb dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Result side: check each transaction, then stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_payload);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_bursts && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Send one pixel transaction; hold the payload while stalled.
   task automatic push_pixel(req_type r);
      if (idle_bursts && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(r);
   endtask

   // One register write; csr_valid drops before the next one.
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   // Drop valid and wait for every predicted pixel; optionally let the pipe settle.
   task automatic drain_results(bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      if (settle) repeat (12) @(posedge clock);
   endtask

   task automatic set_geometry(int w, int h, logic [59:0] k0, logic [59:0] k1,
                               logic [59:0] k2, logic [16:0] bias);
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      write_csr(CSR_KERNEL_TOP_ROW, k0);
      write_csr(CSR_KERNEL_MIDDLE_ROW, k1);
      write_csr(CSR_KERNEL_BOTTOM_ROW, k2);
      write_csr(CSR_OUTPUT_BIAS, {{43{bias[16]}}, bias});
      settings++;
   endtask

   function automatic req_type any_pixel(int drain_odds);
      req_type r;
      r = {1'b0, $urandom};
      r.action = ($urandom_range(0, 99) < drain_odds);
      return r;
   endfunction

   // Kernel row: coefficients within -2.0..2.0 most of the time, full range otherwise.
   function automatic logic [59:0] any_kernel_row();
      logic [59:0] k;
      for (int i = 0; i < 3; i++)
         k[20*i +: 20] = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                     : 20'($signed($urandom_range(0, 1024)) - 512);
      return k;
   endfunction

   // One frame: pixels (with stray drains), then the flush run, then settle.
   task automatic run_frame(int w, int h, int pause_at, bit counted);
      int ew, eh;
      ew = (w == 0) ? 1 : (w > LINE_MAX) ? LINE_MAX : w;
      eh = (h == 0) ? 1 : (h > ROW_LIMIT) ? ROW_LIMIT : h;
      for (int i = 0; i < ew * eh; i++) begin
         if (i == pause_at) drain_results(1'b0);
         push_pixel(any_pixel(5));
         if (counted) random_items++;
      end
      for (int i = 0; i <= ew; i++) begin
         push_pixel(any_pixel(85));
         if (counted) random_items++;
      end
      drain_results(1'b1);
   endtask

   initial begin
      req_type d;
      int w, h;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_data    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity kernel on 3x3: corners, edges, all-zero, all-ones, inner drain.
      set_geometry(3, 3, 60'd0, 60'd256 << 20, 60'd0, 17'd0);
      for (int i = 0; i < 13; i++) begin
         d = (i % 2 == 0) ? req_type'{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF} : req_type'(0);
         if (i == 4 || i >= 9) d.action = 1'b1;
         push_pixel(d);
      end
      drain_results(1'b1);

      // Saturating kernels with extreme biases: clamp high, then clamp low.
      set_geometry(2, 2, {3{20'h7FFFF}}, {3{20'h7FFFF}}, {3{20'h7FFFF}}, 17'h0FFFF);
      run_frame(2, 2, -1, 1'b0);
      set_geometry(2, 2, {3{20'h80000}}, {3{20'h80000}}, {3{20'h80000}}, 17'h10000);
      run_frame(2, 2, -1, 1'b0);

      // Unused register indexes must leave the setting alone.
      write_csr(CSR_SPARE_LOW, {CSR_DATA_W{1'b1}});
      write_csr(CSR_SPARE_HIGH, '0);

      // Geometry extremes: zero sizes act as one.
      set_geometry(0, 0, any_kernel_row(), any_kernel_row(), any_kernel_row(), 17'($urandom));
      run_frame(0, 0, -1, 1'b0);

      // Random frames; pause once mid-frame until all output pixels are out.
      while (random_items < 850) begin
         if (random_items > 700) idle_bursts = 1'b0;
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         set_geometry(w, h, any_kernel_row(), any_kernel_row(), any_kernel_row(),
                      ($urandom_range(0, 1) == 0) ? 17'($urandom)
                                                  : 17'($signed($urandom_range(0, 512)) - 256));
         run_frame(w, h, (settings == 8) ? w * h / 2 : -1, 1'b1);
      end

      drain_results(1'b1);
      repeat (20) @(posedge clock);
      $display("covered %0d settings, %0d frames, %0d transactions in, %0d pixels out",
               settings, sb.frames, sb.accepted, sb.results);
      if (sb.errors == 0 && sb.pending_pixels.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog: a hung handshake must not run forever.
   initial begin
      #60_000_000;
      $display("timeout waiting on the convolver");
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/cv3_pkg.sv
hw/rtl/cv3_queue.sv
hw/rtl/cv3_front.sv
hw/rtl/cv3_back.sv
hw/rtl/convolve_3x3_rgb.sv
tb/convolve_3x3_rgb_test.sv
